[rtl/core/assert_macros.svh]
// Assertion macros shared by the convolution RTL; clk and rst_n come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define C2D3_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define C2D3_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define C2D3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/c2d3_pkg.sv]
// Shared constants and types of the 3x3 convolution unit.
package c2d3_pkg;

  localparam int COEF_W       = 16;
  localparam int KSIZE        = 3;
  localparam int KROW_W       = KSIZE * COEF_W;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = KROW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KROW_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KROW_MID    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KROW_BOT    = 3'd5;

  // Result slots of one pixel, in issue order: previous row / previous column,
  // previous row / this column, this row / previous column, this row / this column.
  localparam int RES_KINDS = 4;
  localparam int RES_NW    = 0;
  localparam int RES_N     = 1;
  localparam int RES_W     = 2;
  localparam int RES_C     = 3;

  typedef struct packed {
    logic [RES_KINDS-1:0] mask;
    logic                 frame_end;
    logic                 ir_zero;
    logic                 ir_one;
    logic                 ic_zero;
    logic                 ic_one;
  } c2d3_flags_t;

endpackage

[rtl/core/conv2d_3x3_replicate_edge_unit.sv]
// Top level of the 3x3 / 1x1 convolution unit with replicated image borders.
//
// Pixels arrive in raster order, one per cycle while in_stall is low; the front
// end keeps two line stores of MAX_WIDTH entries and a 3x3 window, and moves
// each pixel with its result slots into a four-deep queue, stalling the input
// while the queue is full. The back end turns out one result per cycle while
// out_stall is low. In 3x3 mode a pixel causes one result inside the image, two
// at the right edge, two on the last row and four at the last pixel, and fewer
// on the first row or first column; in 1x1 mode each pixel causes one. The
// queue absorbs these bursts. An accepted pixel reaches its first result
// through the line store read, the queue, the multiply, the row sums and the
// final sum into the output register. The line stores need no clearing after
// reset. Configuration is written through the cfg port, which is always ready;
// the user must write it only while the unit is idle; the unit does not enforce this.
`include "assert_macros.svh"

module conv2d_3x3_replicate_edge_unit import c2d3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int FILT_W = PIXEL_BITS + COEF_W + 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [PIXEL_BITS-1:0] in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ROW_W-1:0]            out_row,
  output logic [COL_W-1:0]            out_column,
  output logic signed [FILT_W-1:0]    out_filtered,
  output logic                        out_frame_done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int WIN_W = KSIZE * KSIZE * PIXEL_BITS;
  localparam int Q_W   = WIN_W + ROW_W + COL_W + $bits(c2d3_flags_t);

  logic                      kernel_3x3_r;
  logic [WIDTH_REG_W-1:0]    img_width_r;
  logic [HEIGHT_REG_W-1:0]   img_height_r;
  logic [2:0][KROW_W-1:0]    krow_r;
  logic [COL_W-1:0]          last_col;
  logic [ROW_W-1:0]          last_row;

  logic                            q_push, q_pop, q_empty, q_full;
  logic [2:0][2:0][PIXEL_BITS-1:0] f_win, b_win;
  logic [ROW_W-1:0]                f_ir, b_ir;
  logic [COL_W-1:0]                f_ic, b_ic;
  c2d3_flags_t                     f_flags, b_flags;
  logic [Q_W-1:0]                  q_din, q_dout;

  always_comb begin
    cfg_ready = 1'b1;

    // sizes out of range count as the nearest legal size
    if (img_width_r == '0) begin
      last_col = '0;
    end else if (32'(img_width_r) > 32'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(img_width_r - WIDTH_REG_W'(1));
    end
    if (img_height_r == '0) begin
      last_row = '0;
    end else if (32'(img_height_r) > 32'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(img_height_r - HEIGHT_REG_W'(1));
    end

    q_din = {f_win, f_ir, f_ic, f_flags};
    {b_win, b_ir, b_ic, b_flags} = q_dout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_3x3_r <= 1'b1;
      img_width_r  <= WIDTH_REG_W'(1024);
      img_height_r <= HEIGHT_REG_W'(1024);
      krow_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KERNEL_MODE: kernel_3x3_r <= cfg_data[0];
        CFG_IMG_WIDTH:   img_width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMG_HEIGHT:  img_height_r <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_KROW_TOP:    krow_r[0]    <= cfg_data[KROW_W-1:0];
        CFG_KROW_MID:    krow_r[1]    <= cfg_data[KROW_W-1:0];
        CFG_KROW_BOT:    krow_r[2]    <= cfg_data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  c2d3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .kernel_3x3 (kernel_3x3_r),
    .last_col   (last_col),
    .last_row   (last_row),
    .q_full     (q_full),
    .push       (q_push),
    .win_o      (f_win),
    .ir_o       (f_ir),
    .ic_o       (f_ic),
    .flags_o    (f_flags)
  );

  c2d3_queue #(
    .WIDTH (Q_W),
    .DEPTH (4)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  c2d3_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_win          (b_win),
    .q_ir           (b_ir),
    .q_ic           (b_ic),
    .q_flags        (b_flags),
    .q_pop          (q_pop),
    .kernel_3x3     (kernel_3x3_r),
    .krow           (krow_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_column     (out_column),
    .out_filtered   (out_filtered),
    .out_frame_done (out_frame_done)
  );

endmodule

[rtl/core/c2d3_front.sv]
// Front end: position counters, two line stores, 3x3 window and result classification.
`include "assert_macros.svh"

module c2d3_front import c2d3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [PIXEL_BITS-1:0]         in_pixel,
  input  logic                                 kernel_3x3,
  input  logic [COL_W-1:0]                     last_col,
  input  logic [ROW_W-1:0]                     last_row,
  input  logic                                 q_full,
  output logic                                 push,
  output logic [2:0][2:0][PIXEL_BITS-1:0]      win_o,
  output logic [ROW_W-1:0]                     ir_o,
  output logic [COL_W-1:0]                     ic_o,
  output c2d3_flags_t                          flags_o
);

  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_old_r, rd_new_r;

  logic                          f1_valid_r, f1_valid_nxt;
  logic [PIXEL_BITS-1:0]         f1_pix_r;
  logic [COL_W-1:0]              f1_ic_r;
  logic [ROW_W-1:0]              f1_ir_r;
  c2d3_flags_t                   f1_flags_r, flags_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [ROW_W-1:0]              row_r, row_nxt;
  logic [2:0][2:0][PIXEL_BITS-1:0] win_r, win_nxt;
  logic                          fwd_r, fwd_nxt;
  logic [PIXEL_BITS-1:0]         fwd_old_r, fwd_new_r;
  logic [PIXEL_BITS-1:0]         eff_old, eff_new;
  logic                          accept, leave, is_last, is_bottom;

  always_comb begin
    leave    = f1_valid_r && !q_full;
    in_stall = f1_valid_r && q_full;
    accept   = in_valid && !in_stall;

    // the pixel leaving this cycle wrote the same column the new one reads
    eff_old = fwd_r ? fwd_old_r : rd_old_r;
    eff_new = fwd_r ? fwd_new_r : rd_new_r;

    for (int r = 0; r < KSIZE; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = eff_old;
    win_nxt[1][2] = eff_new;
    win_nxt[2][2] = f1_pix_r;

    is_last   = col_r >= last_col;
    is_bottom = row_r >= last_row;

    flags_nxt.ir_zero   = row_r == '0;
    flags_nxt.ir_one    = row_r == ROW_W'(1);
    flags_nxt.ic_zero   = col_r == '0;
    flags_nxt.ic_one    = col_r == COL_W'(1);
    flags_nxt.frame_end = is_last && is_bottom;
    flags_nxt.mask      = '0;
    if (kernel_3x3) begin
      flags_nxt.mask[RES_NW] = !flags_nxt.ir_zero && !flags_nxt.ic_zero;
      flags_nxt.mask[RES_N]  = !flags_nxt.ir_zero && is_last;
      flags_nxt.mask[RES_W]  = is_bottom && !flags_nxt.ic_zero;
      flags_nxt.mask[RES_C]  = is_bottom && is_last;
    end else begin
      flags_nxt.mask[RES_C]  = 1'b1;
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (is_last) begin
        col_nxt = '0;
        row_nxt = is_bottom ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    f1_valid_nxt = accept ? 1'b1 : (leave ? 1'b0 : f1_valid_r);
    fwd_nxt      = accept ? (leave && (f1_ic_r == col_r)) : fwd_r;

    push    = leave;
    win_o   = win_nxt;
    ir_o    = f1_ir_r;
    ic_o    = f1_ic_r;
    flags_o = f1_flags_r;
  end

  // line stores: read on accept, write when the pixel moves into the queue
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_old_r <= older_mem[col_r];
      rd_new_r <= newer_mem[col_r];
    end
    if (leave) begin
      older_mem[f1_ic_r] <= eff_new;
      newer_mem[f1_ic_r] <= f1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      win_r      <= '0;
      fwd_r      <= 1'b0;
    end else begin
      f1_valid_r <= f1_valid_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fwd_r      <= fwd_nxt;
      if (leave) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix_r   <= in_pixel;
      f1_ic_r    <= col_r;
      f1_ir_r    <= row_r;
      f1_flags_r <= flags_nxt;
      fwd_old_r  <= eff_new;
      fwd_new_r  <= f1_pix_r;
    end
  end

  `C2D3_ASSERT_NEXT(a_fr_take, accept, f1_valid_r, "accepted beat not held in front stage")
  `C2D3_ASSERT_IMPLY(a_fr_col_reset, accept && is_last, col_nxt == '0, "column did not wrap")

endmodule

[rtl/core/c2d3_queue.sv]
// Short register queue between the front end and the arithmetic back end.
`include "assert_macros.svh"

module c2d3_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    empty = cnt_r == '0;
    full  = cnt_r == CNT_W'(DEPTH);
    dout  = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `C2D3_ASSERT_ALWAYS(a_q_bound, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `C2D3_ASSERT_NEXT(a_q_grow, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1), "queue lost a beat")

endmodule

[rtl/core/c2d3_back.sv]
// Back end: issues the results of each queued pixel, multiplies, sums and registers the output.
`include "assert_macros.svh"

module c2d3_back import c2d3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int PROD_W = PIXEL_BITS + COEF_W,
  localparam int RSUM_W = PROD_W + 1,
  localparam int FILT_W = RSUM_W + 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [2:0][2:0][PIXEL_BITS-1:0]   q_win,
  input  logic [ROW_W-1:0]                  q_ir,
  input  logic [COL_W-1:0]                  q_ic,
  input  c2d3_flags_t                       q_flags,
  output logic                              q_pop,
  input  logic                              kernel_3x3,
  input  logic [2:0][KROW_W-1:0]            krow,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ROW_W-1:0]                  out_row,
  output logic [COL_W-1:0]                  out_column,
  output logic signed [FILT_W-1:0]          out_filtered,
  output logic                              out_frame_done
);

  logic                     adv, issue_go, ro, co;
  logic [RES_KINDS-1:0]     issued_r, issued_nxt, pending, pick, rest;
  logic [1:0]               rsel [KSIZE];
  logic [1:0]               csel [KSIZE];
  logic signed [PIXEL_BITS-1:0] tap  [KSIZE][KSIZE];
  logic signed [COEF_W-1:0]     coef [KSIZE][KSIZE];
  logic signed [PROD_W-1:0]     prod_nxt [KSIZE][KSIZE];
  logic [ROW_W-1:0]         row_nxt;
  logic [COL_W-1:0]         col_nxt;

  logic                     p1_valid_r, p2_valid_r, out_valid_r;
  logic signed [PROD_W-1:0] p1_prod_r [KSIZE][KSIZE];
  logic [ROW_W-1:0]         p1_row_r, p2_row_r, out_row_r;
  logic [COL_W-1:0]         p1_col_r, p2_col_r, out_col_r;
  logic                     p1_done_r, p2_done_r, out_done_r;
  logic signed [RSUM_W-1:0] p2_rsum_r [KSIZE];
  logic signed [RSUM_W-1:0] rsum_nxt [KSIZE];
  logic signed [FILT_W-1:0] out_filt_r, filt_nxt;

  always_comb begin
    adv      = !out_valid_r || !out_stall;
    pending  = q_flags.mask & ~issued_r;
    pick     = pending & (~pending + RES_KINDS'(1));
    rest     = pending & ~pick;
    issue_go = adv && !q_empty;
    q_pop    = issue_go && (rest == '0);

    issued_nxt = issued_r;
    if (issue_go) begin
      issued_nxt = (rest == '0) ? '0 : (issued_r | pick);
    end

    ro = pick[RES_W] | pick[RES_C];
    co = pick[RES_N] | pick[RES_C];

    // clamp the window rows and columns against the top and left borders
    rsel[0] = ro ? (q_flags.ir_zero ? 2'd2 : 2'd1) : (q_flags.ir_one ? 2'd1 : 2'd0);
    rsel[1] = ro ? 2'd2 : 2'd1;
    rsel[2] = 2'd2;
    csel[0] = co ? (q_flags.ic_zero ? 2'd2 : 2'd1) : (q_flags.ic_one ? 2'd1 : 2'd0);
    csel[1] = co ? 2'd2 : 2'd1;
    csel[2] = 2'd2;

    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        if (kernel_3x3) begin
          tap[r][c]  = q_win[rsel[r]][csel[c]];
          coef[r][c] = krow[r][c*COEF_W +: COEF_W];
        end else begin
          tap[r][c]  = q_win[2][2];
          coef[r][c] = (r == 0 && c == 0) ? krow[0][COEF_W-1:0] : '0;
        end
        prod_nxt[r][c] = PROD_W'(tap[r][c]) * PROD_W'(coef[r][c]);
      end
    end

    row_nxt = ro ? q_ir : q_ir - ROW_W'(1);
    col_nxt = co ? q_ic : q_ic - COL_W'(1);

    for (int r = 0; r < KSIZE; r++) begin
      rsum_nxt[r] = RSUM_W'(p1_prod_r[r][0]) + RSUM_W'(p1_prod_r[r][1])
                  + RSUM_W'(p1_prod_r[r][2]);
    end
    filt_nxt = FILT_W'(p2_rsum_r[0]) + FILT_W'(p2_rsum_r[1]) + FILT_W'(p2_rsum_r[2]);

    out_valid      = out_valid_r;
    out_row        = out_row_r;
    out_column     = out_col_r;
    out_filtered   = out_filt_r;
    out_frame_done = out_done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= '0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      issued_r <= issued_nxt;
      if (adv) begin
        p1_valid_r  <= issue_go && (pending != '0);
        p2_valid_r  <= p1_valid_r;
        out_valid_r <= p2_valid_r;
      end
    end
  end

  // hold every stage while the output beat waits
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_prod_r  <= prod_nxt;
      p1_row_r   <= row_nxt;
      p1_col_r   <= col_nxt;
      p1_done_r  <= pick[RES_C] && q_flags.frame_end;
      p2_rsum_r  <= rsum_nxt;
      p2_row_r   <= p1_row_r;
      p2_col_r   <= p1_col_r;
      p2_done_r  <= p1_done_r;
      out_filt_r <= filt_nxt;
      out_row_r  <= p2_row_r;
      out_col_r  <= p2_col_r;
      out_done_r <= p2_done_r;
    end
  end

  `C2D3_ASSERT_IMPLY(a_bk_subset, !q_empty, (issued_r & ~q_flags.mask) == '0, "issued slot not in mask")
  `C2D3_ASSERT_IMPLY(a_bk_idle, q_empty, issued_r == '0, "stale issue state with empty queue")

endmodule
